// ----- rtl/kts_pkg.sv -----
// kts_pkg: shared types, constants and helper functions of the keyword token scanner
// depends on nothing; used by kts_lexer, kts_result_fifo, keyword_token_scanner_core and its test bench

package kts_pkg;

	localparam int MaxTokenLength = 255;
	localparam int RunW           = $clog2(MaxTokenLength + 1);
	localparam int MaxPerItem     = 3;
	localparam int FifoDepth      = 8;
	localparam int FifoPtrW       = $clog2(FifoDepth);
	localparam int NumKeywords    = 6;

	typedef logic [RunW-1:0]     run_t;
	typedef logic [FifoPtrW-1:0] ptr_t;
	typedef logic [FifoPtrW:0]   cnt_t;

	typedef enum logic [4:0] {
		K_TAGS     = 5'd0,
		K_BEGIN    = 5'd1,
		K_SEQUENCE = 5'd2,
		K_INTEGER  = 5'd3,
		K_DATE     = 5'd4,
		K_END      = 5'd5,
		K_RANGE    = 5'd6,
		K_ASSIGN   = 5'd7,
		K_LBRACE   = 5'd8,
		K_RBRACE   = 5'd9,
		K_COMMA    = 5'd10,
		K_LPAREN   = 5'd11,
		K_RPAREN   = 5'd12,
		K_TYPEREF  = 5'd13,
		K_IDENT    = 5'd14,
		K_NUMBER   = 5'd15,
		K_INVALID  = 5'd16,
		K_TAB      = 5'd17,
		K_LF       = 5'd18,
		K_VT       = 5'd19,
		K_FF       = 5'd20,
		K_CR       = 5'd21,
		K_SPACE    = 5'd22,
		K_BAR      = 5'd23
	} kind_t;

	typedef enum logic [5:0] {
		MODE_IDLE   = 6'b000001,
		MODE_WORD   = 6'b000010,
		MODE_NUM    = 6'b000100,
		MODE_COLON1 = 6'b001000,
		MODE_COLON2 = 6'b010000,
		MODE_DOT    = 6'b100000
	} mode_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] len;
		logic [7:0] bad;
	} tok_t;

	typedef struct packed {
		logic [1:0]       count;
		tok_t [MaxPerItem-1:0] tok;
	} bundle_t;

	typedef struct packed {
		tok_t tok;
		logic last;
	} entry_t;

	typedef struct packed {
		logic room;
		logic empty;
	} fifo_stat_t;

	localparam logic [7:0] KwText [NumKeywords][8] = '{
		'{"T", "A", "G", "S", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"B", "E", "G", "I", "N", 8'h00, 8'h00, 8'h00},
		'{"S", "E", "Q", "U", "E", "N", "C", "E"},
		'{"I", "N", "T", "E", "G", "E", "R", 8'h00},
		'{"D", "A", "T", "E", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"E", "N", "D", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
	};

	localparam logic [3:0] KwLen [NumKeywords] = '{4'd4, 4'd5, 4'd8, 4'd7, 4'd4, 4'd3};

	function automatic logic is_upper(input logic [7:0] b);
		return b inside {["A":"Z"]};
	endfunction

	function automatic logic is_letter(input logic [7:0] b);
		return b inside {["A":"Z"], ["a":"z"]};
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b inside {["0":"9"]};
	endfunction

	function automatic logic is_word_char(input logic [7:0] b);
		return is_letter(b) || is_digit(b) || (b == "-");
	endfunction

	function automatic logic [7:0] sat_len(input run_t run);
		logic [7:0] r;
		if (run > run_t'(255)) begin
			r = 8'hff;
		end else begin
			r = run[7:0];
		end
		return r;
	endfunction

	function automatic tok_t mk_tok(input kind_t kind, input logic [7:0] len,
			input logic [7:0] bad);
		tok_t t;
		t.kind = kind;
		t.len  = len;
		t.bad  = bad;
		return t;
	endfunction

	// drop every keyword that cannot match byte b at position pos
	function automatic logic [NumKeywords-1:0] narrow(input logic [NumKeywords-1:0] cand,
			input run_t pos, input logic [7:0] b);
		logic [NumKeywords-1:0] c;
		c = cand;
		for (int k = 0; k < NumKeywords; k++) begin
			if (pos >= run_t'(KwLen[k])) begin
				c[k] = 1'b0;
			end else if (KwText[k][pos[2:0]] != b) begin
				c[k] = 1'b0;
			end
		end
		return c;
	endfunction

	function automatic tok_t word_tok(input logic [NumKeywords-1:0] cand, input run_t run,
			input logic up);
		kind_t kind;
		kind = up ? K_TYPEREF : K_IDENT;
		for (int k = NumKeywords - 1; k >= 0; k--) begin
			if (cand[k] && (run == run_t'(KwLen[k]))) begin
				kind = kind_t'(5'(k));
			end
		end
		return mk_tok(kind, sat_len(run), 8'h00);
	endfunction

	// one-byte tokens; anything unlisted is invalid and carries the byte
	function automatic tok_t single_tok(input logic [7:0] b);
		tok_t t;
		t = mk_tok(K_INVALID, 8'd1, 8'h00);
		case (b)
			8'h20:   t.kind = K_SPACE;
			8'h09:   t.kind = K_TAB;
			8'h0a:   t.kind = K_LF;
			8'h0b:   t.kind = K_VT;
			8'h0c:   t.kind = K_FF;
			8'h0d:   t.kind = K_CR;
			"{":     t.kind = K_LBRACE;
			"}":     t.kind = K_RBRACE;
			",":     t.kind = K_COMMA;
			"(":     t.kind = K_LPAREN;
			")":     t.kind = K_RPAREN;
			"|":     t.kind = K_BAR;
			default: t.bad  = b;
		endcase
		return t;
	endfunction

endpackage

// ----- rtl/kts_lexer.sv -----
// kts_lexer: scanner state and the per-byte decode that yields up to three tokens
// depends on kts_pkg

module kts_lexer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic [7:0]        byte_s1,
	input  logic              eoi_s1,
	output kts_pkg::bundle_t  bundle,
	output logic              idle
);

	kts_pkg::mode_t                       mode_q, mode_d;
	kts_pkg::run_t                        run_q, run_d;
	logic [kts_pkg::NumKeywords-1:0]      cand_q, cand_d;
	logic                                 up_q, up_d;
	logic                                 redo;
	logic [1:0]                           n;
	kts_pkg::tok_t [kts_pkg::MaxPerItem-1:0] res;
	kts_pkg::tok_t                        empty_bad;

	assign empty_bad = kts_pkg::mk_tok(kts_pkg::K_INVALID, 8'd0, 8'h00);

	always_comb begin
		mode_d = mode_q;
		run_d  = run_q;
		cand_d = cand_q;
		up_d   = up_q;
		n      = 2'd0;
		res    = '0;
		redo   = 1'b1;

		case (mode_q)
			kts_pkg::MODE_WORD: begin
				if (kts_pkg::is_word_char(byte_s1)) begin
					cand_d = kts_pkg::narrow(cand_d, run_d, byte_s1);
					if (run_d < kts_pkg::run_t'(kts_pkg::MaxTokenLength)) begin
						run_d = run_d + kts_pkg::run_t'(1);
					end
					redo = 1'b0;
				end else begin
					res[n] = kts_pkg::word_tok(cand_d, run_d, up_d);
					n      = n + 2'd1;
					mode_d = kts_pkg::MODE_IDLE;
					run_d  = '0;
				end
			end
			kts_pkg::MODE_NUM: begin
				if (kts_pkg::is_digit(byte_s1)) begin
					if (run_d < kts_pkg::run_t'(kts_pkg::MaxTokenLength)) begin
						run_d = run_d + kts_pkg::run_t'(1);
					end
					redo = 1'b0;
				end else begin
					res[n] = kts_pkg::mk_tok(kts_pkg::K_NUMBER, kts_pkg::sat_len(run_d), 8'h00);
					n      = n + 2'd1;
					mode_d = kts_pkg::MODE_IDLE;
					run_d  = '0;
				end
			end
			kts_pkg::MODE_COLON1: begin
				if (byte_s1 == ":") begin
					mode_d = kts_pkg::MODE_COLON2;
					redo   = 1'b0;
				end else begin
					res[n] = empty_bad;
					n      = n + 2'd1;
					mode_d = kts_pkg::MODE_IDLE;
					run_d  = '0;
				end
			end
			kts_pkg::MODE_COLON2: begin
				if (byte_s1 == "=") begin
					res[n] = kts_pkg::mk_tok(kts_pkg::K_ASSIGN, 8'd3, 8'h00);
					n      = n + 2'd1;
					mode_d = kts_pkg::MODE_IDLE;
					run_d  = '0;
					redo   = 1'b0;
				end else if (byte_s1 == ":") begin
					res[n] = empty_bad;
					n      = n + 2'd1;
					redo   = 1'b0;
				end else begin
					res[n] = empty_bad;
					n      = n + 2'd1;
					res[n] = empty_bad;
					n      = n + 2'd1;
					mode_d = kts_pkg::MODE_IDLE;
					run_d  = '0;
				end
			end
			kts_pkg::MODE_DOT: begin
				if (byte_s1 == ".") begin
					res[n] = kts_pkg::mk_tok(kts_pkg::K_RANGE, 8'd2, 8'h00);
					n      = n + 2'd1;
					redo   = 1'b0;
				end else begin
					res[n] = empty_bad;
					n      = n + 2'd1;
				end
				mode_d = kts_pkg::MODE_IDLE;
				run_d  = '0;
			end
			default: begin
				mode_d = kts_pkg::MODE_IDLE;
				run_d  = '0;
			end
		endcase

		if (redo) begin
			if (kts_pkg::is_letter(byte_s1)) begin
				mode_d = kts_pkg::MODE_WORD;
				cand_d = kts_pkg::narrow('1, '0, byte_s1);
				run_d  = kts_pkg::run_t'(1);
				up_d   = kts_pkg::is_upper(byte_s1);
			end else if (kts_pkg::is_digit(byte_s1)) begin
				mode_d = kts_pkg::MODE_NUM;
				run_d  = kts_pkg::run_t'(1);
			end else if (byte_s1 == ":") begin
				mode_d = kts_pkg::MODE_COLON1;
			end else if (byte_s1 == ".") begin
				mode_d = kts_pkg::MODE_DOT;
			end else begin
				res[n] = kts_pkg::single_tok(byte_s1);
				n      = n + 2'd1;
			end
		end

		// flush whatever is pending at end of input
		if (eoi_s1) begin
			case (mode_d)
				kts_pkg::MODE_WORD: begin
					res[n] = kts_pkg::word_tok(cand_d, run_d, up_d);
					n      = n + 2'd1;
				end
				kts_pkg::MODE_NUM: begin
					res[n] = kts_pkg::mk_tok(kts_pkg::K_NUMBER, kts_pkg::sat_len(run_d), 8'h00);
					n      = n + 2'd1;
				end
				kts_pkg::MODE_COLON1, kts_pkg::MODE_DOT: begin
					res[n] = empty_bad;
					n      = n + 2'd1;
				end
				kts_pkg::MODE_COLON2: begin
					res[n] = empty_bad;
					n      = n + 2'd1;
					res[n] = empty_bad;
					n      = n + 2'd1;
				end
				default: begin
				end
			endcase
			mode_d = kts_pkg::MODE_IDLE;
			run_d  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= kts_pkg::MODE_IDLE;
			run_q  <= '0;
			cand_q <= '1;
			up_q   <= 1'b0;
		end else if (adv) begin
			mode_q <= mode_d;
			run_q  <= run_d;
			cand_q <= cand_d;
			up_q   <= up_d;
		end
	end

	assign bundle.count = n;
	assign bundle.tok   = res;
	assign idle         = (mode_q == kts_pkg::MODE_IDLE);

endmodule

// ----- rtl/kts_result_fifo.sv -----
// kts_result_fifo: result queue taking up to three tokens per cycle, giving one per cycle
// depends on kts_pkg

module kts_result_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  kts_pkg::bundle_t    bundle,
	input  logic                pop,
	output kts_pkg::entry_t     head,
	output kts_pkg::fifo_stat_t stat
);

	kts_pkg::entry_t mem [kts_pkg::FifoDepth];
	kts_pkg::entry_t head_q;
	kts_pkg::ptr_t   wr_ptr_q, rd_ptr_q;
	kts_pkg::cnt_t   count_q;
	logic [1:0]      n_push;

	assign n_push = push ? bundle.count : 2'd0;

	always_ff @(posedge clk) begin
		for (int i = 0; i < kts_pkg::MaxPerItem; i++) begin
			if (push && (2'(i) < bundle.count)) begin
				mem[wr_ptr_q + kts_pkg::ptr_t'(i)] <= {bundle.tok[i], (2'(i + 1) == bundle.count)};
			end
		end
		// head comes straight from the incoming tokens when nothing older is left
		if (count_q == kts_pkg::cnt_t'(pop)) begin
			head_q <= {bundle.tok[0], (bundle.count == 2'd1)};
		end else begin
			head_q <= mem[rd_ptr_q + kts_pkg::ptr_t'(pop)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + kts_pkg::ptr_t'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + kts_pkg::ptr_t'(1);
			end
			count_q <= count_q + kts_pkg::cnt_t'(n_push) - kts_pkg::cnt_t'(pop);
		end
	end

	assign head       = head_q;
	assign stat.empty = (count_q == '0);
	assign stat.room  = (count_q <= kts_pkg::cnt_t'(kts_pkg::FifoDepth - kts_pkg::MaxPerItem));

endmodule

// ----- rtl/keyword_token_scanner_core.sv -----
// keyword_token_scanner_core: top level of the byte-stream keyword token scanner
// depends on kts_pkg, kts_lexer and kts_result_fifo
//
//   channel | handshake            | payload
//   --------+----------------------+----------------------------------------------
//   in      | in_valid / in_ready  | in_byte, end_of_input
//   out     | out_valid/ out_ready | token_kind, token_length, bad_byte, last_of_run
//
// one byte per cycle: an item is registered, then decoded, and its 0..3 tokens land in an
// 8-entry result queue; the first token shows once the head register of the queue loads it
// the queue drains one token per cycle, so bytes giving several tokens or a stalled
// output side hold the input off once fewer than three queue slots are free
// reset puts the scanner idle with an empty queue

module keyword_token_scanner_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       end_of_input,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [4:0] token_kind,
	output logic [7:0] token_length,
	output logic [7:0] bad_byte,
	output logic       last_of_run
);

	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                eoi_s1;
	logic                adv;
	logic                idle;
	kts_pkg::bundle_t    bundle;
	kts_pkg::entry_t     head;
	kts_pkg::fifo_stat_t stat;

	assign adv      = valid_s1 && stat.room;
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
			eoi_s1  <= end_of_input;
		end
	end

	kts_lexer u_lexer (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.byte_s1 (byte_s1),
		.eoi_s1  (eoi_s1),
		.bundle  (bundle),
		.idle    (idle)
	);

	kts_result_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (adv),
		.bundle (bundle),
		.pop    (out_valid && out_ready),
		.head   (head),
		.stat   (stat)
	);

	assign out_valid    = !stat.empty;
	assign token_kind   = head.tok.kind;
	assign token_length = head.tok.len;
	assign bad_byte     = head.tok.bad;
	assign last_of_run  = head.last;

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("accepted item not held in input stage");

	a_eoi_idle: assert property (@(posedge clk) disable iff (!arst_n)
		adv && eoi_s1 |=> idle)
		else $error("scanner not idle after end of input");

	a_tokens_visible: assert property (@(posedge clk) disable iff (!arst_n)
		adv && (bundle.count != 2'd0) |=> out_valid)
		else $error("pushed tokens not visible at output");

endmodule

// ----- tb/keyword_token_scanner_core_test.sv -----
// keyword_token_scanner_core_test: self-checking bench for the byte-stream keyword token scanner
// holds a token predictor, directed and random byte streams, and random idling on both channels
// depends on kts_pkg and keyword_token_scanner_core

module keyword_token_scanner_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RUN_CAP     = 255;
	localparam int CYCLE_LIMIT = 200000;
	localparam int TAIL_CYCLES = 10;

	typedef enum logic [5:0] {
		SC_IDLE   = 6'b000001,
		SC_WORD   = 6'b000010,
		SC_NUM    = 6'b000100,
		SC_COLON  = 6'b001000,
		SC_COLON2 = 6'b010000,
		SC_DOT    = 6'b100000
	} scan_state_t;

	typedef struct {
		kts_pkg::kind_t kind;
		logic [7:0]     len;
		logic [7:0]     bad;
		logic           last;
	} token_rec_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] in_byte = 8'h00;
	logic       end_of_input = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b1;
	logic [4:0] token_kind;
	logic [7:0] token_length;
	logic [7:0] bad_byte;
	logic       last_of_run;

	token_rec_t  expected_tokens[$];
	logic [7:0]  line_buf[$];
	int          mismatches = 0;
	bit          idling_on = 1'b1;
	bit          stall_on = 1'b1;

	scan_state_t sc_state = SC_IDLE;
	int unsigned sc_run = 0;
	logic [5:0]  sc_cand = 6'h3f;
	logic        sc_upper = 1'b0;

	string       kw_spell[6] = '{"TAGS", "BEGIN", "SEQUENCE", "INTEGER", "DATE", "END"};
	logic [7:0]  separators[12] = '{8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d,
		"{", "}", ",", "(", ")", "|"};

	keyword_token_scanner_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_byte      (in_byte),
		.end_of_input (end_of_input),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.token_kind   (token_kind),
		.token_length (token_length),
		.bad_byte     (bad_byte),
		.last_of_run  (last_of_run)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic bit upper_byte(input logic [7:0] b);
		return b >= "A" && b <= "Z";
	endfunction

	function automatic bit letter_byte(input logic [7:0] b);
		return upper_byte(b) || (b >= "a" && b <= "z");
	endfunction

	function automatic bit digit_byte(input logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic void put_char(input logic [7:0] c);
		line_buf = {line_buf, c};
	endfunction

	function automatic void add_token(input kts_pkg::kind_t kind, input int unsigned len,
			input logic [7:0] bad);
		token_rec_t rec;
		rec.kind = kind;
		rec.len  = (len > RUN_CAP) ? 8'(RUN_CAP) : 8'(len);
		rec.bad  = bad;
		rec.last = 1'b0;
		expected_tokens = {expected_tokens, rec};
	endfunction

	function automatic void drop_keywords(input int unsigned pos, input logic [7:0] b);
		for (int k = 0; k < 6; k++) begin
			if (pos >= kw_spell[k].len()) begin
				sc_cand[k] = 1'b0;
			end else if (kw_spell[k][pos] != b) begin
				sc_cand[k] = 1'b0;
			end
		end
	endfunction

	function automatic void add_word();
		kts_pkg::kind_t kind;
		bit             found;
		kind  = sc_upper ? kts_pkg::K_TYPEREF : kts_pkg::K_IDENT;
		found = 1'b0;
		for (int k = 0; k < 6; k++) begin
			if (!found && sc_cand[k] && sc_run == kw_spell[k].len()) begin
				kind  = kts_pkg::kind_t'(5'(k));
				found = 1'b1;
			end
		end
		add_token(kind, sc_run, 8'h00);
	endfunction

	function automatic void open_token(input logic [7:0] b);
		if (letter_byte(b)) begin
			sc_state = SC_WORD;
			sc_cand  = 6'h3f;
			drop_keywords(0, b);
			sc_run   = 1;
			sc_upper = upper_byte(b);
		end else if (digit_byte(b)) begin
			sc_state = SC_NUM;
			sc_run   = 1;
		end else begin
			case (b)
				":":     sc_state = SC_COLON;
				".":     sc_state = SC_DOT;
				8'h20:   add_token(kts_pkg::K_SPACE, 1, 8'h00);
				8'h09:   add_token(kts_pkg::K_TAB, 1, 8'h00);
				8'h0a:   add_token(kts_pkg::K_LF, 1, 8'h00);
				8'h0b:   add_token(kts_pkg::K_VT, 1, 8'h00);
				8'h0c:   add_token(kts_pkg::K_FF, 1, 8'h00);
				8'h0d:   add_token(kts_pkg::K_CR, 1, 8'h00);
				"{":     add_token(kts_pkg::K_LBRACE, 1, 8'h00);
				"}":     add_token(kts_pkg::K_RBRACE, 1, 8'h00);
				",":     add_token(kts_pkg::K_COMMA, 1, 8'h00);
				"(":     add_token(kts_pkg::K_LPAREN, 1, 8'h00);
				")":     add_token(kts_pkg::K_RPAREN, 1, 8'h00);
				"|":     add_token(kts_pkg::K_BAR, 1, 8'h00);
				default: add_token(kts_pkg::K_INVALID, 1, b);
			endcase
		end
	endfunction

	// predict the tokens caused by one accepted item
	function automatic void scan_byte(input logic [7:0] b, input logic eoi);
		int first_new;
		bit reopen;
		first_new = expected_tokens.size();
		reopen    = 1'b1;
		case (sc_state)
			SC_WORD: begin
				if (letter_byte(b) || digit_byte(b) || b == "-") begin
					drop_keywords(sc_run, b);
					if (sc_run < RUN_CAP) sc_run++;
					reopen = 1'b0;
				end else begin
					add_word();
					sc_state = SC_IDLE;
				end
			end
			SC_NUM: begin
				if (digit_byte(b)) begin
					if (sc_run < RUN_CAP) sc_run++;
					reopen = 1'b0;
				end else begin
					add_token(kts_pkg::K_NUMBER, sc_run, 8'h00);
					sc_state = SC_IDLE;
				end
			end
			SC_COLON: begin
				if (b == ":") begin
					sc_state = SC_COLON2;
					reopen   = 1'b0;
				end else begin
					add_token(kts_pkg::K_INVALID, 0, 8'h00);
					sc_state = SC_IDLE;
				end
			end
			SC_COLON2: begin
				if (b == "=") begin
					add_token(kts_pkg::K_ASSIGN, 3, 8'h00);
					sc_state = SC_IDLE;
					reopen   = 1'b0;
				end else if (b == ":") begin
					add_token(kts_pkg::K_INVALID, 0, 8'h00);
					reopen = 1'b0;
				end else begin
					add_token(kts_pkg::K_INVALID, 0, 8'h00);
					add_token(kts_pkg::K_INVALID, 0, 8'h00);
					sc_state = SC_IDLE;
				end
			end
			SC_DOT: begin
				if (b == ".") begin
					add_token(kts_pkg::K_RANGE, 2, 8'h00);
					sc_state = SC_IDLE;
					reopen   = 1'b0;
				end else begin
					add_token(kts_pkg::K_INVALID, 0, 8'h00);
					sc_state = SC_IDLE;
				end
			end
			default: sc_state = SC_IDLE;
		endcase
		if (sc_state == SC_IDLE) sc_run = 0;
		if (reopen) open_token(b);
		if (eoi) begin
			case (sc_state)
				SC_WORD:  add_word();
				SC_NUM:   add_token(kts_pkg::K_NUMBER, sc_run, 8'h00);
				SC_COLON,
				SC_DOT:   add_token(kts_pkg::K_INVALID, 0, 8'h00);
				SC_COLON2: begin
					add_token(kts_pkg::K_INVALID, 0, 8'h00);
					add_token(kts_pkg::K_INVALID, 0, 8'h00);
				end
				default: ;
			endcase
			sc_state = SC_IDLE;
			sc_run   = 0;
		end
		if (expected_tokens.size() > first_new) begin
			expected_tokens[expected_tokens.size() - 1].last = 1'b1;
		end
	endfunction

	task automatic push_byte(input logic [7:0] b, input logic eoi);
		int gap;
		gap = 0;
		if (idling_on && $urandom_range(99) < 6) gap = 1;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		in_byte      <= b;
		end_of_input <= eoi;
		do @(posedge clk); while (!in_ready);
		scan_byte(b, eoi);
	endtask

	function automatic void add_chars(input string s);
		for (int i = 0; i < s.len(); i++) put_char(s[i]);
	endfunction

	// send the buffered line; stray end flags land anywhere when asked
	task automatic send_line(input bit eoi_last, input bit stray_eoi);
		logic eoi;
		for (int i = 0; i < line_buf.size(); i++) begin
			eoi = (eoi_last && i == line_buf.size() - 1) ||
				(stray_eoi && $urandom_range(99) < 2);
			push_byte(line_buf[i], eoi);
		end
		line_buf.delete();
	endtask

	task automatic send_text(input string s, input bit eoi_last);
		add_chars(s);
		send_line(eoi_last, 1'b0);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_tokens.size() != 0);
	endtask

	task automatic test_keywords();
		send_text("TAGS BEGIN SEQUENCE INTEGER DATE ", 1'b0);
		send_text("END", 1'b1);
		send_text("ENDS Begin x-9 ", 1'b0);
	endtask

	task automatic test_single_marks();
		send_text(" \t\n\v\f\r{},()|::=..", 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(8'hff, 1'b0);
		push_byte(8'h7f, 1'b0);
	endtask

	task automatic test_lone_colon_dot();
		send_text(":a ::b :::= .c ", 1'b0);
	endtask

	task automatic test_flush_at_end();
		send_text(":", 1'b1);
		send_text("::", 1'b1);
		send_text(".", 1'b1);
		send_text("Ab1", 1'b1);
		send_text("42", 1'b1);
	endtask

	// no idling here: the one long quiet stretch
	task automatic test_long_runs();
		wait_drained();
		idling_on = 1'b0;
		stall_on  = 1'b0;
		add_chars("END");
		for (int i = 0; i < 14; i++) put_char((i % 3 == 0) ? "-" : "q");
		put_char(8'h20);
		for (int i = 0; i < 12; i++) put_char("0" + 8'(i % 10));
		send_line(1'b1, 1'b0);
		idling_on = 1'b1;
		stall_on  = 1'b1;
	endtask

	function automatic logic [7:0] rand_word_char();
		logic [7:0] c;
		case ($urandom_range(0, 3))
			0:       c = "a" + 8'($urandom_range(0, 25));
			1:       c = "A" + 8'($urandom_range(0, 25));
			2:       c = "0" + 8'($urandom_range(0, 9));
			default: c = "-";
		endcase
		return c;
	endfunction

	task automatic test_random_text();
		int    sent;
		int    pick;
		int    k;
		int    n;
		bit    paused;
		string kw;
		sent   = 0;
		paused = 1'b0;
		while (sent < 12) begin
			pick = $urandom_range(0, 19);
			if (pick < 5) begin
				k  = $urandom_range(0, 5);
				kw = kw_spell[k];
				case ($urandom_range(0, 3))
					2:       kw = kw.substr(0, kw.len() - 2);
					3:       kw = {kw, "S"};
					default: ;
				endcase
				add_chars(kw);
			end else if (pick < 9) begin
				put_char((pick < 7) ? "a" + 8'($urandom_range(0, 25)) :
					"A" + 8'($urandom_range(0, 25)));
				n = $urandom_range(0, 7);
				repeat (n) put_char(rand_word_char());
			end else if (pick < 11) begin
				n = $urandom_range(1, 6);
				repeat (n) put_char("0" + 8'($urandom_range(0, 9)));
			end else if (pick < 13) begin
				add_chars(($urandom_range(0, 1) == 0) ? "::=" : "..");
			end else if (pick < 16) begin
				case ($urandom_range(0, 4))
					0:       add_chars(":");
					1:       add_chars("::");
					2:       add_chars(":::=");
					3:       add_chars(".");
					default: add_chars("::::");
				endcase
				put_char(($urandom_range(0, 1) == 0) ? rand_word_char() :
					separators[$urandom_range(0, 11)]);
			end else if (pick < 18) begin
				put_char(separators[$urandom_range(0, 11)]);
			end else begin
				n = $urandom_range(1, 3);
				repeat (n) put_char(8'($urandom_range(0, 255)));
			end
			if ($urandom_range(99) < 75) put_char(separators[$urandom_range(0, 11)]);
			sent += line_buf.size();
			send_line($urandom_range(9) == 0, 1'b1);
			if (!paused && sent >= 6) begin
				wait_drained();
				paused = 1'b1;
			end
		end
	endtask

	task automatic finish_run();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_tokens.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_keywords();
		test_single_marks();
		test_lone_colon_dot();
		test_flush_at_end();
		test_long_runs();
		test_random_text();
		finish_run();
	end

	initial begin
		token_rec_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (expected_tokens.size() == 0) begin
					$error("unexpected token: kind %0d, length %0d", token_kind, token_length);
					mismatches++;
				end else begin
					want = expected_tokens.pop_front();
					if (token_kind != want.kind) begin
						$error("token_kind: expected %0d, got %0d", want.kind, token_kind);
						mismatches++;
					end
					if (token_length != want.len) begin
						$error("token_length: expected %0d, got %0d", want.len, token_length);
						mismatches++;
					end
					if (bad_byte != want.bad) begin
						$error("bad_byte: expected 0x%02h, got 0x%02h", want.bad, bad_byte);
						mismatches++;
					end
					if (last_of_run != want.last) begin
						$error("last_of_run: expected %0b, got %0b", want.last, last_of_run);
						mismatches++;
					end
				end
			end
			out_ready <= !(stall_on && $urandom_range(99) < 6);
		end
	end

	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/kts_pkg.sv
rtl/kts_lexer.sv
rtl/kts_result_fifo.sv
rtl/keyword_token_scanner_core.sv
tb/keyword_token_scanner_core_test.sv
